/* hdl/dtm_pkg.sv */
// Shared types and constants for the divider timer with modulo reload.
package dtm_pkg;

  // Request kinds carried on the input side
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Register selects
  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_CNT  = 2'd1;
  localparam logic [1:0] REG_MOD  = 2'd2;
  localparam logic [1:0] REG_CTRL = 2'd3;

  // Divider reset value and step per machine-cycle tick
  localparam logic [15:0] DIV_RESET = 16'hABCC;
  localparam logic [15:0] DIV_STEP  = 16'd4;

  // Control register layout
  localparam int CTRL_W   = 3;
  localparam int CTRL_EN  = 2;

  // One input item
  typedef struct packed {
    logic [7:0] write_data;
    logic [1:0] reg_sel;
    logic [1:0] req_type;
  } dtm_item_t;

  // One result item
  typedef struct packed {
    logic       timer_irq;
    logic [7:0] read_data;
  } dtm_result_t;

  // Divider bit watched for a given rate field
  function automatic logic watch_bit(input logic [15:0] div, input logic [1:0] rate);
    logic b;
    case (rate)
      2'd0:    b = div[9];
      2'd1:    b = div[3];
      2'd2:    b = div[5];
      default: b = div[7];
    endcase
    return b;
  endfunction

endpackage

/* hdl/divider_timer_modulo_reload_unit.sv */
// Top level of the divider timer with modulo reload, stream ports on both sides.
//
// Each transfer on the input is a machine-cycle tick, a register read or a register
// write (the fourth request code is ignored), and yields exactly one result transfer.
// An item passes an input register, then the timer update and result forming run
// combinationally into the output register, so one item is taken per clock while the
// output register is empty or being drained; out_tvalid rises once the item reaches
// the output register, and the result transfer completes when out_tready is high.
// The dtm_core state updates only when an item advances out of the input register.
module divider_timer_modulo_reload_unit import dtm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] write_data
  input  logic [3:0]  in_tuser,   // [1:0] req_type, [3:2] reg_sel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_data, [8] timer_irq, [15:9] zero
);

  dtm_item_t   item_r;
  logic        item_vld_r;
  dtm_result_t res, res_r;
  logic        out_vld_r;
  logic        advance;
  logic        in_fire;

  assign advance   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.req_type   <= in_tuser[1:0];
      item_r.reg_sel    <= in_tuser[3:2];
      item_r.write_data <= in_tdata;
    end
  end

  dtm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .res     (res)
  );

  // Hold the result until the output transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, res_r.timer_irq, res_r.read_data};

endmodule

/* hdl/dtm_core.sv */
// Timer state registers and the single-pass update for one request.
module dtm_core import dtm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,   // item in the input register moves on this cycle
  input  dtm_item_t   item,
  output dtm_result_t res
);

  logic [15:0]       div_r, div_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [7:0]        mod_r, mod_nxt;
  logic [CTRL_W-1:0] ctrl_r, ctrl_nxt;
  logic              pend_r, pend_nxt;

  logic [15:0] div_inc;
  logic [7:0]  cnt_inc;
  logic        en;
  logic        old_bit;
  logic        inc_en;

  assign div_inc = div_r + DIV_STEP;
  assign cnt_inc = cnt_r + 8'd1;
  assign en      = ctrl_r[CTRL_EN];
  assign old_bit = watch_bit(div_r, ctrl_r[1:0]);

  // Decode the request and form next state and result
  always_comb begin
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    mod_nxt  = mod_r;
    ctrl_nxt = ctrl_r;
    pend_nxt = pend_r;
    inc_en   = 1'b0;
    res      = '0;
    case (item.req_type)
      REQ_TICK: begin
        div_nxt = div_inc;
        if (en) begin
          if (pend_r) begin
            cnt_nxt       = mod_r;
            res.timer_irq = 1'b1;
            pend_nxt      = 1'b0;
          end else if (old_bit && !watch_bit(div_inc, ctrl_r[1:0])) begin
            inc_en = 1'b1;
          end
        end
      end
      REQ_READ: begin
        case (item.reg_sel)
          REG_DIV:  res.read_data = div_r[15:8];
          REG_CNT:  res.read_data = cnt_r;
          REG_MOD:  res.read_data = mod_r;
          default:  res.read_data = {{(8-CTRL_W){1'b0}}, ctrl_r};
        endcase
      end
      REQ_WRITE: begin
        case (item.reg_sel)
          REG_DIV: begin
            inc_en  = en && old_bit;
            div_nxt = '0;
          end
          REG_CNT: cnt_nxt = item.write_data;
          REG_MOD: mod_nxt = item.write_data;
          default: begin
            if (en) begin
              if (!item.write_data[CTRL_EN]) begin
                inc_en = old_bit;
              end else begin
                inc_en = old_bit && !watch_bit(div_r, item.write_data[1:0]);
              end
            end
            ctrl_nxt = item.write_data[CTRL_W-1:0];
          end
        endcase
      end
      default: ;
    endcase
    // Edge and glitch increments share the wrap check
    if (inc_en) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc == 8'd0) pend_nxt = 1'b1;
    end
  end

  // Hold state unless an item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= DIV_RESET;
      cnt_r  <= '0;
      mod_r  <= '0;
      ctrl_r <= '0;
      pend_r <= 1'b0;
    end else if (advance) begin
      div_r  <= div_nxt;
      cnt_r  <= cnt_nxt;
      mod_r  <= mod_nxt;
      ctrl_r <= ctrl_nxt;
      pend_r <= pend_nxt;
    end
  end

  // An interrupt is only given while enabled with an overflow pending
  a_irq_src: assert property (@(posedge clk) disable iff (!rst_n)
    res.timer_irq |-> (pend_r && en && item.req_type == REQ_TICK))
    else $error("irq without pending overflow");

  // A served overflow clears the pending flag and reloads the counter
  a_irq_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.timer_irq) |=> (!pend_r && cnt_r == $past(mod_r)))
    else $error("overflow not served");

  // A divider write clears the divider
  a_div_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item.req_type == REQ_WRITE && item.reg_sel == REG_DIV) |=> (div_r == 16'd0))
    else $error("divider write did not clear");

  // State holds while no item advances
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(div_r) && $stable(cnt_r) && $stable(pend_r)))
    else $error("state changed without an item");

endmodule

/* tb/sv/tb_divider_timer_modulo_reload_unit.sv */
// Self-checking bench for the divider timer: directed table, random traffic, stream backpressure.
module tb_divider_timer_modulo_reload_unit;
  import dtm_pkg::*;

  // Request code that the block must ignore
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Divider bit watched per rate field, as a mask (half the edge period)
  localparam logic [15:0] RATE_MASK [4] = '{16'h0200, 16'h0008, 16'h0020, 16'h0080};

  localparam int PHASE_ITEMS = 264;
  localparam int STALL_LIMIT = 3000;

  typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH, PH_PRESSURE} phase_t;

  // One directed row; the expected result counts only where fixed is set
  typedef struct packed {
    logic [1:0] req;
    logic [1:0] sel;
    logic [7:0] data;
    logic       fixed;
    logic [7:0] rd;
    logic       irq;
  } dir_row_t;

  localparam int DIR_ROWS = 27;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{REQ_READ,  REG_DIV,  8'h00, 1'b1, 8'hAB, 1'b0},  // divider upper byte after reset
    '{REQ_READ,  REG_CNT,  8'h00, 1'b1, 8'h00, 1'b0},
    '{REQ_READ,  REG_MOD,  8'h00, 1'b1, 8'h00, 1'b0},
    '{REQ_READ,  REG_CTRL, 8'h00, 1'b1, 8'h00, 1'b0},
    '{REQ_NONE,  REG_CTRL, 8'hFF, 1'b1, 8'h00, 1'b0},  // ignored request
    '{REQ_WRITE, REG_MOD,  8'hFF, 1'b0, 8'h00, 1'b0},
    '{REQ_READ,  REG_MOD,  8'h00, 1'b1, 8'hFF, 1'b0},
    '{REQ_WRITE, REG_CNT,  8'hFF, 1'b0, 8'h00, 1'b0},
    '{REQ_WRITE, REG_CTRL, 8'h05, 1'b0, 8'h00, 1'b0},  // enable, fast rate
    '{REQ_TICK,  REG_DIV,  8'h00, 1'b0, 8'h00, 1'b0},  // edge wraps the counter
    '{REQ_TICK,  REG_DIV,  8'h00, 1'b0, 8'h00, 1'b0},  // reload and interrupt
    '{REQ_READ,  REG_CNT,  8'h00, 1'b0, 8'h00, 1'b0},
    '{REQ_WRITE, REG_CNT,  8'hFF, 1'b0, 8'h00, 1'b0},
    '{REQ_TICK,  REG_DIV,  8'h00, 1'b0, 8'h00, 1'b0},
    '{REQ_WRITE, REG_DIV,  8'h5A, 1'b0, 8'h00, 1'b0},  // divider clear with glitch wrap
    '{REQ_WRITE, REG_CTRL, 8'h00, 1'b0, 8'h00, 1'b0},  // disable with overflow pending
    '{REQ_TICK,  REG_DIV,  8'h00, 1'b0, 8'h00, 1'b0},  // pending held while disabled
    '{REQ_READ,  REG_DIV,  8'h00, 1'b0, 8'h00, 1'b0},
    '{REQ_WRITE, REG_CTRL, 8'h07, 1'b0, 8'h00, 1'b0},
    '{REQ_TICK,  REG_DIV,  8'h00, 1'b0, 8'h00, 1'b0},  // pending served now
    '{REQ_WRITE, REG_CNT,  8'hFF, 1'b0, 8'h00, 1'b0},
    '{REQ_WRITE, REG_CTRL, 8'h05, 1'b0, 8'h00, 1'b0},
    '{REQ_WRITE, REG_CTRL, 8'h04, 1'b0, 8'h00, 1'b0},  // rate change glitch wraps
    '{REQ_WRITE, REG_CTRL, 8'h05, 1'b0, 8'h00, 1'b0},
    '{REQ_WRITE, REG_CTRL, 8'hF9, 1'b0, 8'h00, 1'b0},  // disable glitch, upper bits dropped
    '{REQ_READ,  REG_CTRL, 8'h00, 1'b0, 8'h00, 1'b0},
    '{REQ_TICK,  REG_DIV,  8'h00, 1'b0, 8'h00, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] write_data
  logic [3:0]  in_tuser;   // [1:0] req_type, [3:2] reg_sel
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] read_data, [8] timer_irq, [15:9] zero

  // Timer state as the predictor sees it
  logic [15:0]       tm_div;
  logic [7:0]        tm_cnt;
  logic [7:0]        tm_mod;
  logic [CTRL_W-1:0] tm_ctrl;
  logic              tm_ovf;

  dtm_result_t due_results [$];
  int          err_count;
  phase_t      phase;

  divider_timer_modulo_reload_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Increment the counter; a wrap to zero leaves an overflow pending
  function automatic void bump_counter();
    tm_cnt = tm_cnt + 8'd1;
    if (tm_cnt == 8'd0) tm_ovf = 1'b1;
  endfunction

  // Apply one request to the timer state and form its result
  function automatic dtm_result_t predict_timer_step(input dtm_item_t it);
    dtm_result_t r;
    logic [15:0] prev;
    logic [15:0] om;
    r = '0;
    om = RATE_MASK[tm_ctrl[1:0]];
    case (it.req_type)
      REQ_TICK: begin
        prev = tm_div;
        tm_div = tm_div + DIV_STEP;
        if (tm_ctrl[CTRL_EN]) begin
          if (tm_ovf) begin
            tm_cnt = tm_mod;
            r.timer_irq = 1'b1;
            tm_ovf = 1'b0;
          end else if ((prev & om) != 16'd0 && (tm_div & om) == 16'd0) begin
            bump_counter();
          end
        end
      end
      REQ_READ: begin
        case (it.reg_sel)
          REG_DIV: r.read_data = tm_div[15:8];
          REG_CNT: r.read_data = tm_cnt;
          REG_MOD: r.read_data = tm_mod;
          default: r.read_data = {5'd0, tm_ctrl};
        endcase
      end
      REQ_WRITE: begin
        case (it.reg_sel)
          REG_DIV: begin
            if (tm_ctrl[CTRL_EN] && (tm_div & om) != 16'd0) bump_counter();
            tm_div = 16'd0;
          end
          REG_CNT: tm_cnt = it.write_data;
          REG_MOD: tm_mod = it.write_data;
          default: begin
            // Falling edge seen through the select mux on disable or rate change
            if (tm_ctrl[CTRL_EN] && (tm_div & om) != 16'd0) begin
              if (!it.write_data[CTRL_EN] ||
                  (tm_div & RATE_MASK[it.write_data[1:0]]) == 16'd0)
                bump_counter();
            end
            tm_ctrl = it.write_data[CTRL_W-1:0];
          end
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // Pick a random request, biased toward an enabled fast timer and near-wrap counts
  function automatic dtm_item_t random_request();
    dtm_item_t it;
    int pick;
    it.req_type = REQ_TICK;
    it.reg_sel = 2'($urandom_range(3));
    it.write_data = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 55) begin
      it.req_type = REQ_TICK;
    end else if (pick < 72) begin
      it.req_type = REQ_READ;
    end else if (pick < 96) begin
      it.req_type = REQ_WRITE;
      if (it.reg_sel == REG_CNT && $urandom_range(1) == 0)
        it.write_data = 8'($urandom_range(255, 240));
      if (it.reg_sel == REG_CTRL && $urandom_range(99) < 80) begin
        it.write_data[CTRL_EN] = 1'b1;
        it.write_data[1:0] = ($urandom_range(1) == 0) ? 2'd1 : 2'($urandom_range(3));
      end
    end else begin
      it.req_type = REQ_NONE;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_result(input logic [15:0] data);
    dtm_result_t got;
    dtm_result_t want;
    got = data[8:0];
    if (due_results.size() == 0) begin
      report_mismatch("result with nothing due", int'(got), 0);
    end else begin
      want = due_results.pop_front();
      if (got.read_data !== want.read_data)
        report_mismatch("read_data", int'(got.read_data), int'(want.read_data));
      if (got.timer_irq !== want.timer_irq)
        report_mismatch("timer_irq", int'(got.timer_irq), int'(want.timer_irq));
    end
  endtask

  // Offer one request, wait for its transfer, then queue the expected result
  task automatic send_request(input dtm_item_t it, input logic fixed, input dtm_result_t want);
    dtm_result_t pred;
    int idle_pct;
    idle_pct = (phase == PH_SRC_IDLE) ? 74 : (phase == PH_BOTH) ? 31 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.write_data;
    in_tuser  <= {it.reg_sel, it.req_type};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_timer_step(it);
    due_results.push_back(fixed ? want : pred);
  endtask

  // Result side: check transfers and drive tready per phase
  initial begin
    int hold_left;
    bit held_once;
    int stall_pct;
    hold_left = 0;
    held_once = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
      if (phase == PH_PRESSURE && hold_left == 0 &&
          (!held_once || $urandom_range(199) == 0)) begin
        hold_left = $urandom_range(80, 40);
        held_once = 1'b1;
      end
      stall_pct = (phase == PH_SNK_STALL) ? 74 : (phase == PH_BOTH) ? 31 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Stop a run that makes no progress on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("divider_timer_modulo_reload_unit: mismatch");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin
    dtm_item_t it;
    dtm_result_t want;
    err_count = 0;
    phase = PH_FREE;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    tm_div = DIV_RESET;
    tm_cnt = 8'd0;
    tm_mod = 8'd0;
    tm_ctrl = '0;
    tm_ovf = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      it.req_type = dir_table[i].req;
      it.reg_sel = dir_table[i].sel;
      it.write_data = dir_table[i].data;
      want.read_data = dir_table[i].rd;
      want.timer_irq = dir_table[i].irq;
      send_request(it, dir_table[i].fixed, want);
    end

    // Random traffic under each flow-control pattern
    want = '0;
    for (int p = PH_FREE; p <= PH_PRESSURE; p++) begin
      phase = phase_t'(p);
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request(), 1'b0, want);
    end
    in_tvalid <= 1'b0;
    phase = PH_FREE;

    // Drain, then allow for stray results
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("divider_timer_modulo_reload_unit: match");
    end else begin
      $display("divider_timer_modulo_reload_unit: mismatch");
    end
    $finish;
  end

endmodule

/* divider_timer_modulo_reload_unit.f */
hdl/dtm_pkg.sv
hdl/dtm_core.sv
hdl/divider_timer_modulo_reload_unit.sv
tb/sv/tb_divider_timer_modulo_reload_unit.sv
